>>> hdl/proxy_pdu_reassembler_top_macros.svh
// ----------------------------------------------------------------------------
// Proxy PDU reassembler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef PROXY_PDU_REASSEMBLER_TOP_MACROS_SVH
`define PROXY_PDU_REASSEMBLER_TOP_MACROS_SVH

// same-cycle implication
`define PPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ppr assertion failed");

// next-cycle implication
`define PPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppr assertion failed");

`endif

>>> hdl/ppr_pkg.sv
// ----------------------------------------------------------------------------
// ppr_pkg
// Header codes and fixed constants of the proxy PDU reassembler.
// ----------------------------------------------------------------------------
package ppr_pkg;

  localparam logic [1:0] SAR_COMPLETE = 2'd0;
  localparam logic [1:0] SAR_FIRST    = 2'd1;
  localparam logic [1:0] SAR_CONTINUE = 2'd2;
  localparam logic [1:0] SAR_LAST     = 2'd3;

  localparam logic [5:0] HDR_TYPE_MASK = 6'h3F;
  localparam logic [5:0] TYPE_PROV     = 6'd3;
  localparam int         HDR_SAR_SHIFT = 6;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

endpackage

>>> hdl/ppr_front.sv
// ----------------------------------------------------------------------------
// ppr_front
// Parses segment headers, tracks segment room and commit length, and issues
// store-write / deliver commands to the back end.
// ----------------------------------------------------------------------------
module ppr_front #(
  parameter  int BUF_DEPTH = 64,
  localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int LW        = $clog2(BUF_DEPTH + 1),
  localparam int CMD_W     = 2 + 2 * AW + 8 + LW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            rx_byte,
  input  logic                  seg_end,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [CMD_W-1:0]      q_data
);

  typedef struct packed {
    logic          wr;
    logic [AW-1:0] addr;
    logic [7:0]    data;
    logic          dlv;
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } cmd_t;

  logic          expect_header;
  logic [1:0]    sar_code;
  logic          type_ok;
  logic [LW-1:0] committed_len;
  logic [LW-1:0] seg_count;
  logic          seg_overflow;

  logic [LW-1:0] committed_len_next;
  logic [LW-1:0] seg_count_next;
  logic          seg_overflow_next;

  logic [1:0]    sar_e;
  logic          tok_e;
  logic [LW-1:0] cnt_e;
  logic          ovf_e;
  logic [LW:0]   wr_pos;
  logic [LW:0]   sum_len;
  logic          accept;
  cmd_t          cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    sar_e  = expect_header ? rx_byte[7:ppr_pkg::HDR_SAR_SHIFT] : sar_code;
    tok_e  = expect_header ? ((rx_byte[5:0] & ppr_pkg::HDR_TYPE_MASK) == ppr_pkg::TYPE_PROV)
                           : type_ok;
    cnt_e  = expect_header ? '0 : seg_count;
    ovf_e  = expect_header ? 1'b0 : seg_overflow;
    wr_pos = (sar_e == ppr_pkg::SAR_FIRST) ? {1'b0, cnt_e}
                                           : {1'b0, committed_len} + {1'b0, cnt_e};
    cmd       = '0;
    cmd.data  = rx_byte;
    cmd.addr  = wr_pos[AW-1:0];
    committed_len_next = committed_len;

    if (!expect_header && type_ok && !seg_overflow) begin
      if (wr_pos < (LW + 1)'(BUF_DEPTH)) begin
        cmd.wr = 1'b1;
        cnt_e  = seg_count + LW'(1);
      end else begin
        ovf_e = 1'b1;
      end
    end

    sum_len = {1'b0, committed_len} + {1'b0, cnt_e};

    if (seg_end && tok_e) begin
      if (ovf_e) begin
        // a dropped first segment has already clobbered the message
        if (sar_e == ppr_pkg::SAR_FIRST) committed_len_next = '0;
      end else begin
        case (sar_e)
          ppr_pkg::SAR_COMPLETE: begin
            cmd.dlv   = 1'b1;
            cmd.start = committed_len[AW-1:0];
            cmd.len   = cnt_e;
          end
          ppr_pkg::SAR_FIRST: committed_len_next = cnt_e;
          ppr_pkg::SAR_CONTINUE: committed_len_next = sum_len[LW-1:0];
          ppr_pkg::SAR_LAST: begin
            cmd.dlv   = 1'b1;
            cmd.start = '0;
            cmd.len   = sum_len[LW-1:0];
            committed_len_next = '0;
          end
          default: committed_len_next = committed_len;
        endcase
      end
    end

    seg_count_next    = seg_end ? '0 : cnt_e;
    seg_overflow_next = seg_end ? 1'b0 : ovf_e;
  end

  assign q_push = accept && (cmd.wr || cmd.dlv);
  assign q_data = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      sar_code      <= ppr_pkg::SAR_COMPLETE;
      type_ok       <= 1'b0;
      committed_len <= '0;
      seg_count     <= '0;
      seg_overflow  <= 1'b0;
    end else if (accept) begin
      expect_header <= seg_end;
      sar_code      <= sar_e;
      type_ok       <= tok_e;
      committed_len <= committed_len_next;
      seg_count     <= seg_count_next;
      seg_overflow  <= seg_overflow_next;
    end
  end

endmodule

>>> hdl/ppr_cmdq.sv
// ----------------------------------------------------------------------------
// ppr_cmdq
// Small command FIFO decoupling the parser from the store / delivery side.
// ----------------------------------------------------------------------------
module ppr_cmdq #(
  parameter int CMD_W = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [CMD_W-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [CMD_W-1:0] pop_data
);

  logic [CMD_W-1:0]            slots [ppr_pkg::QUEUE_DEPTH];
  logic [ppr_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ppr_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ppr_pkg::QUEUE_AW:0]   count;

  assign full      = (count == (ppr_pkg::QUEUE_AW + 1)'(ppr_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + ppr_pkg::QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + ppr_pkg::QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (ppr_pkg::QUEUE_AW + 1)'(1);
        2'b01:   count <= count - (ppr_pkg::QUEUE_AW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

endmodule

>>> hdl/ppr_back.sv
// ----------------------------------------------------------------------------
// ppr_back
// Owns the assembly store: applies byte writes and streams delivered
// messages out, one beat per cycle while the receiver is ready, through the registered read port.
// ----------------------------------------------------------------------------
`include "proxy_pdu_reassembler_top_macros.svh"

module ppr_back #(
  parameter  int BUF_DEPTH = 64,
  localparam int AW        = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1,
  localparam int LW        = $clog2(BUF_DEPTH + 1),
  localparam int CMD_W     = 2 + 2 * AW + 8 + LW
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic [CMD_W-1:0] cmd_data,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       msg_byte,
  output logic             msg_last,
  output logic             msg_empty
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DATA = 2'd1;
  localparam logic [1:0] ST_NULL = 2'd2;

  typedef struct packed {
    logic          wr;
    logic [AW-1:0] addr;
    logic [7:0]    data;
    logic          dlv;
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } cmd_t;

  logic [7:0]    store [BUF_DEPTH];
  logic [1:0]    st;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] remain;
  logic [7:0]    rd_q;
  logic          last_q;
  logic          empty_q;
  logic          slot_free;
  logic          emit;
  cmd_t          c;

  assign c         = cmd_data;
  assign cmd_pop   = (st == ST_IDLE) && cmd_valid;
  assign slot_free = !out_valid || out_ready;
  assign emit      = slot_free && ((st == ST_DATA) || (st == ST_NULL));

  assign msg_byte  = empty_q ? 8'h00 : rd_q;
  assign msg_last  = last_q;
  assign msg_empty = empty_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      out_valid <= 1'b0;
      rd_addr   <= '0;
      remain    <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (cmd_pop && c.dlv) begin
            rd_addr <= c.start;
            remain  <= c.len;
            st      <= (c.len == '0) ? ST_NULL : ST_DATA;
          end
        end
        ST_DATA: begin
          if (slot_free) begin
            rd_addr   <= rd_addr + AW'(1);
            remain    <= remain - LW'(1);
            if (remain == LW'(1)) st <= ST_IDLE;
          end
        end
        ST_NULL: begin
          if (slot_free) begin
            st        <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // store port and output payload register
  always_ff @(posedge clk) begin
    if (cmd_pop && c.wr) store[c.addr] <= c.data;
    if (st == ST_DATA && slot_free) begin
      rd_q    <= store[rd_addr];
      last_q  <= (remain == LW'(1));
      empty_q <= 1'b0;
    end else if (st == ST_NULL && slot_free) begin
      last_q  <= 1'b1;
      empty_q <= 1'b1;
    end
  end

  `PPR_ASSERT_IMP(a_data_remain, st == ST_DATA, remain != '0)
  `PPR_ASSERT_IMP(a_empty_last, out_valid && msg_empty, msg_last)
  `PPR_ASSERT_NXT(a_dlv_enter, cmd_pop && c.dlv && (c.len != '0), st == ST_DATA)
  `PPR_ASSERT_NXT(a_stream_emit, st == ST_DATA && slot_free, out_valid && !msg_empty)

endmodule

>>> hdl/proxy_pdu_reassembler_top.sv
// Proxy PDU reassembler: takes segment bytes one beat per cycle (header byte
// first, seg_end on the last byte), keeps provisioning (type 3) payloads in a
// BUF_DEPTH-byte store and delivers each finished message as a run of beats
// with msg_last on the final one; an empty message is one beat with msg_empty
// set. Input beats are taken at one per cycle while the four-entry command
// queue has room. A delivered message occupies the store's single read port
// while it streams out, during which store writes queue up behind it and the
// input stalls once the queue fills. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// proxy_pdu_reassembler_top
// Front parser, command queue and store/delivery back end.
// ----------------------------------------------------------------------------
module proxy_pdu_reassembler_top #(
  parameter int BUF_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       seg_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] msg_byte,
  output logic       msg_last,
  output logic       msg_empty
);

  localparam int AW    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LW    = $clog2(BUF_DEPTH + 1);
  localparam int CMD_W = 2 + 2 * AW + 8 + LW;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_not_empty;
  logic [CMD_W-1:0] q_in;
  logic [CMD_W-1:0] q_out;

  ppr_front #(.BUF_DEPTH(BUF_DEPTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .seg_end  (seg_end),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  ppr_cmdq #(.CMD_W(CMD_W)) u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  ppr_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd_data  (q_out),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .msg_byte  (msg_byte),
    .msg_last  (msg_last),
    .msg_empty (msg_empty)
  );

endmodule

>>> dv/tb_proxy_pdu_reassembler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proxy_pdu_reassembler_top
// Drives proxy segments byte by byte into the reassembler and checks every
// delivered message beat against a cycle-free model of the SAR reassembly.
// ----------------------------------------------------------------------------
module tb_proxy_pdu_reassembler_top;

  localparam int STORE_DEPTH = 64;
  localparam int ITEM_TARGET = 470;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       seg_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] msg_byte;
  logic       msg_last;
  logic       msg_empty;

  bit calm = 1'b0;       // no idling on either side
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int bytes_sent = 0;
  int cycles = 0;

  class reassembly_sb;
    typedef struct {
      logic [7:0] data;
      logic       last;
      logic       empty;
    } msg_beat_t;

    bit          hdr_next = 1'b1;
    logic [1:0]  sar = ppr_pkg::SAR_COMPLETE;
    bit          prov = 1'b0;
    logic [7:0]  store [STORE_DEPTH];
    int unsigned built_len = 0;
    int unsigned seg_len = 0;
    bit          overflow = 1'b0;
    msg_beat_t   msg_beats_due[$];
    int          errors = 0;
    int          beats_in = 0;
    int          beats_out = 0;
    int          msgs = 0;
    int          empties = 0;

    function void queue_msg(input int unsigned start, input int unsigned len);
      msg_beat_t mb;
      msgs++;
      if (len == 0) begin
        empties++;
        mb.data = 8'h00;
        mb.last = 1'b1;
        mb.empty = 1'b1;
        msg_beats_due.push_back(mb);
      end else begin
        for (int unsigned k = 0; k < len; k++) begin
          mb.data = store[start + k];
          mb.last = (k + 1 == len);
          mb.empty = 1'b0;
          msg_beats_due.push_back(mb);
        end
      end
    endfunction

    function void take_rx_beat(input logic [7:0] b, input logic last_b);
      int unsigned slot;
      beats_in++;
      if (hdr_next) begin
        sar = 2'(b >> ppr_pkg::HDR_SAR_SHIFT);
        prov = ((b[5:0] & ppr_pkg::HDR_TYPE_MASK) == ppr_pkg::TYPE_PROV);
        hdr_next = 1'b0;
        seg_len = 0;
        overflow = 1'b0;
      end else if (prov && !overflow) begin
        // first segments overwrite from the bottom of the store
        slot = ((sar == ppr_pkg::SAR_FIRST) ? 0 : built_len) + seg_len;
        if (slot < STORE_DEPTH) begin
          store[slot] = b;
          seg_len++;
        end else begin
          overflow = 1'b1;
        end
      end
      if (last_b) begin
        if (prov) begin
          if (overflow) begin
            // the old message was already overwritten by the dropped first
            if (sar == ppr_pkg::SAR_FIRST) built_len = 0;
          end else begin
            case (sar)
              ppr_pkg::SAR_COMPLETE: queue_msg(built_len, seg_len);
              ppr_pkg::SAR_FIRST:    built_len = seg_len;
              ppr_pkg::SAR_CONTINUE: built_len += seg_len;
              ppr_pkg::SAR_LAST: begin
                built_len += seg_len;
                queue_msg(0, built_len);
                built_len = 0;
              end
              default: ;
            endcase
          end
        end
        hdr_next = 1'b1;
        seg_len = 0;
        overflow = 1'b0;
      end
    endfunction

    function void check_msg_beat(input logic [7:0] d, input logic l, input logic e);
      msg_beat_t mb;
      beats_out++;
      if (msg_beats_due.size() == 0) begin
        $error("unexpected message beat: msg_byte %0h msg_last %0b msg_empty %0b", d, l, e);
        errors++;
        return;
      end
      mb = msg_beats_due.pop_front();
      // msg_byte carries nothing on an empty message
      if (!mb.empty && d !== mb.data) begin
        $error("msg_byte mismatch: expected %0h, actual %0h", mb.data, d);
        errors++;
      end
      if (l !== mb.last) begin
        $error("msg_last mismatch: expected %0b, actual %0b", mb.last, l);
        errors++;
      end
      if (e !== mb.empty) begin
        $error("msg_empty mismatch: expected %0b, actual %0b", mb.empty, e);
        errors++;
      end
    endfunction
  endclass

  reassembly_sb sb = new();

  proxy_pdu_reassembler_top #(
    .BUF_DEPTH(STORE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .seg_end  (seg_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .msg_byte (msg_byte),
    .msg_last (msg_last),
    .msg_empty(msg_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // beats seen at the edge, input first
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.take_rx_beat(rx_byte, seg_end);
      if (out_valid && out_ready) sb.check_msg_beat(msg_byte, msg_last, msg_empty);
    end
  end

  // receiver: random back-pressure, one long hold on request
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 14);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic e);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    seg_end  <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_segment(input logic [1:0] s, input logic [5:0] typ, input int len);
    send_beat({s, typ}, len == 0);
    for (int i = 0; i < len; i++) send_beat(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // let the last accepted beat reach the scoreboard before waiting
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.msg_beats_due.size() != 0) @(posedge clk);
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 14) == 0) return $urandom_range(7, 30);
    return $urandom_range(0, 6);
  endfunction

  initial begin
    int          r;
    int          calm_from;
    bit          calm_seen;
    logic [5:0]  typ;
    logic [1:0]  s;

    calm_from = $urandom_range(220, 280);
    calm_seen = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: every SAR code, empty deliveries, foreign types, byte extremes
    send_beat({ppr_pkg::SAR_COMPLETE, ppr_pkg::TYPE_PROV}, 1'b1);
    send_beat({ppr_pkg::SAR_COMPLETE, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat({ppr_pkg::SAR_FIRST, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'hFF, 1'b1);
    send_beat({ppr_pkg::SAR_CONTINUE, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h5A, 1'b1);
    send_beat({ppr_pkg::SAR_LAST, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'hA5, 1'b1);
    send_beat({ppr_pkg::SAR_LAST, ppr_pkg::TYPE_PROV}, 1'b1);
    send_beat({ppr_pkg::SAR_FIRST, 6'h3F}, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b1);
    // complete in the middle of a message leaves it intact
    send_beat({ppr_pkg::SAR_FIRST, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'h11, 1'b1);
    send_beat({ppr_pkg::SAR_COMPLETE, ppr_pkg::TYPE_PROV}, 1'b0);
    send_beat(8'h22, 1'b1);
    send_beat({ppr_pkg::SAR_LAST, ppr_pkg::TYPE_PROV}, 1'b1);
    send_beat({ppr_pkg::SAR_LAST, 6'h00}, 1'b1);
    wait_drained();

    while (bytes_sent < ITEM_TARGET) begin
      if (!hold_req && bytes_sent > 120) begin
        hold_req = 1'b1;
        send_segment(ppr_pkg::SAR_COMPLETE, ppr_pkg::TYPE_PROV, 12);
      end
      if (!calm_seen && bytes_sent >= calm_from) begin
        calm = 1'b1;
        calm_seen = 1'b1;
      end
      if (calm && bytes_sent >= calm_from + 80) begin
        calm = 1'b0;
        wait_drained();
      end

      r = $urandom_range(0, 99);
      if (r < 55) begin
        send_segment(ppr_pkg::SAR_FIRST, ppr_pkg::TYPE_PROV, pick_len());
        repeat ($urandom_range(0, 3))
          send_segment(ppr_pkg::SAR_CONTINUE, ppr_pkg::TYPE_PROV, pick_len());
        send_segment(ppr_pkg::SAR_LAST, ppr_pkg::TYPE_PROV, pick_len());
      end else if (r < 70) begin
        send_segment(ppr_pkg::SAR_COMPLETE, ppr_pkg::TYPE_PROV, pick_len());
      end else if (r < 80) begin
        do typ = 6'($urandom_range(0, 63)); while (typ == ppr_pkg::TYPE_PROV);
        send_segment(2'($urandom_range(0, 3)), typ, pick_len());
      end else if (r < 90) begin
        // stray continue or last with no first before it
        s = $urandom_range(0, 1) ? ppr_pkg::SAR_CONTINUE : ppr_pkg::SAR_LAST;
        send_segment(s, ppr_pkg::TYPE_PROV, pick_len());
      end else if (r < 98) begin
        send_segment(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)), pick_len());
      end else begin
        // oversized: may run past the store, and is then dropped
        send_segment(2'($urandom_range(0, 3)), ppr_pkg::TYPE_PROV, $urandom_range(60, 70));
      end
    end

    calm = 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.msg_beats_due.size() != 0) begin
      $error("%0d message beats never delivered", sb.msg_beats_due.size());
      sb.errors++;
    end
    $display("Sent %0d segment bytes; got %0d message beats in %0d messages (%0d empty),",
             sb.beats_in, sb.beats_out, sb.msgs, sb.empties);
    $display("with a %0d-cycle receiver hold and drained pauses.", HOLD_CYCLES);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
